// File: src/ghst_pkg.sv
// ----------------------------------------------------------------------------
// ghst_pkg - shared types and constants
// Operation codes, status codes, controller states and the command
// struct that runs from the controller to the datapath.
// ----------------------------------------------------------------------------
package ghst_pkg;

	// operation codes (code 3 behaves as retrieve)
	localparam logic [1:0] FN_SPAWN    = 2'd0;
	localparam logic [1:0] FN_RETRIEVE = 2'd1;
	localparam logic [1:0] FN_REMOVE   = 2'd2;

	// result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_RANGE    = 3'd2;
	localparam logic [2:0] ST_NONE     = 3'd3;
	localparam logic [2:0] ST_INACTIVE = 3'd4;
	localparam logic [2:0] ST_MISMATCH = 3'd5;

	// free-slot search: slots are grouped, first a group, then a slot in it
	localparam int GRP_W = 4;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FIND,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic load;  // capture the command fields
		logic find;  // group search / table read
		logic exec;  // check, update, register the result
	} cmd_t;

endpackage

// File: src/ghst_ctrl.sv
// ----------------------------------------------------------------------------
// ghst_ctrl - sequencing controller
// Steps each accepted command through find and execute phases.
// ----------------------------------------------------------------------------
module ghst_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output ghst_pkg::cmd_t cmd
);
	import ghst_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		busy     = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_FIND;
				end
			end
			S_FIND: begin
				cmd.find = 1'b1;
				state_d  = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// find is always followed by execute
	a_find_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIND) |=> (state_q == S_EXEC))
		else $error("find phase not followed by execute");

	// execute only ever comes straight after find
	a_exec_after_find: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> $past(cmd.find))
		else $error("execute without preceding find");

endmodule

// File: src/ghst_dp.sv
// ----------------------------------------------------------------------------
// ghst_dp - slot table datapath
// Active bits, generation/type memory, global generation counter,
// two-level free-slot search and the result register.
// ----------------------------------------------------------------------------
module ghst_dp #(
	parameter int SLOT_COUNT = 128,
	parameter int GEN_BITS   = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ghst_pkg::cmd_t cmd,
	input  logic [1:0]     func,
	input  logic [7:0]     slot_id,
	input  logic [15:0]    handle_generation,
	input  logic [3:0]     object_type,
	output logic           done,
	output logic [2:0]     status,
	output logic [7:0]     out_slot_id,
	output logic [15:0]    out_generation,
	output logic [3:0]     out_type
);
	import ghst_pkg::*;

	// index width kept at least one group-index bit wide
	localparam int ID_W   = ($clog2(SLOT_COUNT) < GRP_W + 1) ? GRP_W + 1
	                                                         : $clog2(SLOT_COUNT);
	localparam int PAD    = 1 << ID_W;
	localparam int GSIZE  = 1 << GRP_W;
	localparam int NGRP   = PAD >> GRP_W;
	localparam int GIDX_W = ID_W - GRP_W;

	// captured command
	logic [1:0]          func_q;
	logic [7:0]          slot_id_q;
	logic [GEN_BITS-1:0] hgen_q;
	logic [3:0]          otype_q;

	logic [SLOT_COUNT-1:0] active_q;
	logic [GEN_BITS-1:0]   gen_ctr_q;

	logic [GEN_BITS-1:0] gen_mem [0:SLOT_COUNT-1];
	logic [3:0]          type_mem [0:SLOT_COUNT-1];
	logic [GEN_BITS-1:0] rd_gen_q;
	logic [3:0]          rd_type_q;

	logic [GIDX_W-1:0] grp_q;
	logic              free_q;

	logic [PAD-1:0]    occ;
	logic [NGRP-1:0]   grp_full;
	logic [GIDX_W-1:0] grp_sel;
	logic              grp_any;
	logic [GSIZE-1:0]  grp_bits;
	logic [GRP_W-1:0]  bit_sel;
	logic [ID_W-1:0]   free_slot;
	logic [ID_W-1:0]   idx;
	logic [31:0]       hgen32;

	// result of the execute phase
	logic [2:0]          res_status;
	logic [7:0]          res_id;
	logic [GEN_BITS-1:0] res_gen;
	logic [3:0]          res_type;
	logic                do_spawn;
	logic                do_remove;
	logic                in_range;
	logic                matched;
	logic [31:0]         res_gen32;

	// padding slots past the table read as occupied
	genvar gi;
	generate
		for (gi = 0; gi < PAD; gi++) begin : g_occ
			if (gi < SLOT_COUNT) begin : g_real
				assign occ[gi] = active_q[gi];
			end else begin : g_pad
				assign occ[gi] = 1'b1;
			end
		end
		for (gi = 0; gi < NGRP; gi++) begin : g_full
			assign grp_full[gi] = &occ[gi*GSIZE +: GSIZE];
		end
	endgenerate

	// lowest group with a free slot
	always_comb begin
		grp_sel = '0;
		grp_any = 1'b0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (!grp_full[g]) begin
				grp_sel = GIDX_W'(g);
				grp_any = 1'b1;
			end
		end
	end

	// lowest free slot inside the chosen group
	always_comb begin
		grp_bits = occ[grp_q*GSIZE +: GSIZE];
		bit_sel  = '0;
		for (int b = GSIZE - 1; b >= 0; b--) begin
			if (!grp_bits[b]) begin
				bit_sel = GRP_W'(b);
			end
		end
	end

	assign free_slot = {grp_q, bit_sel};
	assign idx       = slot_id_q[ID_W-1:0];
	assign hgen32    = 32'(handle_generation);

	// checks and result
	always_comb begin
		in_range   = (slot_id_q < 8'(SLOT_COUNT));
		matched    = (rd_gen_q == hgen_q) && (rd_type_q == otype_q);
		do_spawn   = 1'b0;
		do_remove  = 1'b0;
		res_status = ST_OK;
		res_id     = '0;
		res_gen    = '0;
		res_type   = '0;
		if (func_q == FN_SPAWN) begin
			if (free_q) begin
				do_spawn = 1'b1;
				res_id   = 8'(free_slot);
				res_gen  = gen_ctr_q;
				res_type = otype_q;
			end else begin
				res_status = ST_FULL;
			end
		end else if (func_q == FN_REMOVE && otype_q == 4'd0) begin
			res_status = ST_NONE;
		end else if (!in_range) begin
			res_status = ST_RANGE;
		end else if (!occ[idx]) begin
			res_status = ST_INACTIVE;
		end else if (!matched) begin
			res_status = ST_MISMATCH;
		end else begin
			do_remove = (func_q == FN_REMOVE);
			res_id    = slot_id_q;
			res_gen   = rd_gen_q;
			res_type  = rd_type_q;
		end
		res_gen32 = 32'(res_gen);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q    <= func;
			slot_id_q <= slot_id;
			hgen_q    <= hgen32[GEN_BITS-1:0];
			otype_q   <= object_type;
		end
		if (cmd.find) begin
			grp_q  <= grp_sel;
			free_q <= grp_any;
		end
		if (cmd.exec) begin
			status         <= res_status;
			out_slot_id    <= res_id;
			out_generation <= res_gen32[15:0];
			out_type       <= res_type;
		end
	end

	// generation / type store; stale entries are masked by the active bit
	always_ff @(posedge clk) begin
		if (cmd.find) begin
			rd_gen_q  <= gen_mem[idx];
			rd_type_q <= type_mem[idx];
		end
		if (cmd.exec && do_spawn) begin
			gen_mem[free_slot]  <= gen_ctr_q;
			type_mem[free_slot] <= otype_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= '0;
			gen_ctr_q <= '0;
			done      <= 1'b0;
		end else begin
			done <= cmd.exec;
			if (cmd.exec && do_spawn) begin
				active_q[free_slot] <= 1'b1;
			end
			if (cmd.exec && do_remove) begin
				active_q[idx] <= 1'b0;
				gen_ctr_q     <= gen_ctr_q + GEN_BITS'(1);
			end
		end
	end

endmodule

// File: src/generational_handle_slot_table.sv
// ----------------------------------------------------------------------------
// generational_handle_slot_table - handle slot table
// Hands out handles (slot, generation, type); checks and frees them.
// ----------------------------------------------------------------------------
//
//  channel   | ports                                         | transfer when
//  ----------+-----------------------------------------------+----------------
//  command   | func, slot_id, handle_generation, object_type | start & !busy
//  result    | status, out_slot_id, out_generation, out_type | done
//
// Sequence: each command runs from transfer to the next transfer through
//   the accept cycle, a find phase (lowest group with a free slot, table
//   read at slot_id) and an execute phase (slot pick in the group, checks,
//   table update). The result is on the ports with done in the cycle after
//   execute, when busy is already low again.
// Reset: arst_n clears every active bit, the generation counter and the
//   controller; no clearing pass is needed, stored generation/type of a
//   free slot is never observed.
// Stalls: the receiver cannot stall; done is high for exactly one cycle.
// ----------------------------------------------------------------------------
module generational_handle_slot_table #(
	parameter int SLOT_COUNT = 128,
	parameter int GEN_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// command side
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [7:0]  slot_id,
	input  logic [15:0] handle_generation,
	input  logic [3:0]  object_type,
	// result side
	output logic        done,
	output logic [2:0]  status,
	output logic [7:0]  out_slot_id,
	output logic [15:0] out_generation,
	output logic [3:0]  out_type
);
	import ghst_pkg::*;

	cmd_t cmd;

	// controller: IDLE -> FIND -> EXEC
	ghst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// datapath: active bits, generation/type store, counter, result register
	ghst_dp #(
		.SLOT_COUNT (SLOT_COUNT),
		.GEN_BITS   (GEN_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.func              (func),
		.slot_id           (slot_id),
		.handle_generation (handle_generation),
		.object_type       (object_type),
		.done              (done),
		.status            (status),
		.out_slot_id       (out_slot_id),
		.out_generation    (out_generation),
		.out_type          (out_type)
	);

	// a transfer in makes the block busy next cycle
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command transfer did not raise busy");

	// a result appears only as the block comes out of busy
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("result outside end of command");

	// failed commands return an all-zero handle
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |->
			(out_slot_id == 8'd0 && out_generation == 16'd0 && out_type == 4'd0))
		else $error("non-zero handle on failure");

endmodule
